FILE: rtl/gbn_pkg.sv
// Package: shared types and constants for the greedy box suppression block.
`timescale 1ns / 1ps
package gbn_pkg;
   localparam int MAX_KEPT_DEF   = 256;
   localparam int COORD_BITS_DEF = 16;
   localparam int IOU_W   = 17;
   localparam int SCORE_W = 16;
   localparam int LIMIT_W = 9;
   localparam int INDEX_W = 16;
   localparam int LABEL_W = 8;
   localparam int COORD_W = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_ADDR_W = 2;

   localparam logic [IOU_W-1:0]   IOU_RESET   = 17'd32768;
   localparam logic [SCORE_W-1:0] SCORE_RESET = 16'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd100;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IOU   = 2'd0,
      CSR_SCORE = 2'd1,
      CSR_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BELOW  = 3'd0,
      ST_SUPPR  = 3'd1,
      ST_KEPT   = 3'd2,
      ST_LIMIT  = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CALC, S_MULT, S_CMP, S_DONE
   } state_type;

   typedef struct packed {
      logic                 start_req;
      logic [INDEX_W-1:0]   box_index;
      logic [LABEL_W-1:0]   class_label;
      logic [SCORE_W-1:0]   score;
      logic [COORD_W-1:0]   left;
      logic [COORD_W-1:0]   top;
      logic [COORD_W-1:0]   right;
      logic [COORD_W-1:0]   bottom;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  out_index;
      logic [LABEL_W-1:0]  out_label;
      logic [SCORE_W-1:0]  out_score;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] index;
      logic [31:0]           data;
   } csr_type;
endpackage

FILE: rtl/gbn_if.sv
// Interfaces: valid/ready channel carrying a packed payload.
`timescale 1ns / 1ps
interface gbn_req_if;
   import gbn_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gbn_rsp_if;
   import gbn_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gbn_csr_if;
   import gbn_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/greedy_box_nms.sv
// Top level: greedy non-maximum suppression with a kept-box memory.
`timescale 1ns / 1ps
// Flow: a request is taken in S_IDLE; each kept box scanned costs a memory read (S_READ) and
// a 3-step overlap test (S_CALC, S_MULT, S_CMP); below score no box is scanned; a hit ends the
// scan early. One request at a time: the response holds in S_DONE until taken, then S_IDLE.
// Scan time is set by the single read port and shared IoU datapath.
// Reset: synchronous; clears the kept count, state and registers; memory unused.
module greedy_box_nms #(
   parameter int MAX_KEPT   = gbn_pkg::MAX_KEPT_DEF,
   parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   gbn_req_if.sink   req,
   gbn_rsp_if.source rsp,
   gbn_csr_if.sink   csr
);
   import gbn_pkg::*;

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int EW = COORD_BITS + 1;      // extent width
   localparam int AR = 2 * EW;              // area width
   localparam int UW = AR + 1;              // union width

   // configuration registers
   logic [IOU_W-1:0]   iou_ff;
   logic [SCORE_W-1:0] sthr_ff;
   logic [LIMIT_W-1:0] limit_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         iou_ff   <= IOU_RESET;
         sthr_ff  <= SCORE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr.valid) begin
         case (csr.data.index)
            CSR_IOU:   iou_ff   <= csr.data.data[IOU_W-1:0];
            CSR_SCORE: sthr_ff  <= csr.data.data[SCORE_W-1:0];
            CSR_LIMIT: limit_ff <= csr.data.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // kept-box memory
   logic [4*COORD_BITS+LABEL_W-1:0] mem [MAX_KEPT];
   logic [4*COORD_BITS+LABEL_W-1:0] rd_ff;
   logic                            wr_en;
   logic [AW-1:0]                   rd_addr;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  scan_ff, scan_in;
   req_type        box_ff;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic           capture;

   logic [COORD_BITS-1:0] bl, bt, br, bb;
   assign bl = box_ff.left[COORD_BITS-1:0];
   assign bt = box_ff.top[COORD_BITS-1:0];
   assign br = box_ff.right[COORD_BITS-1:0];
   assign bb = box_ff.bottom[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[count_ff[AW-1:0]] <= {box_ff.class_label, bb, br, bt, bl};
      rd_ff <= mem[rd_addr];
   end
   assign rd_addr = scan_ff[AW-1:0];

   function automatic logic [EW-1:0] extent(input logic [COORD_BITS-1:0] lo,
                                            input logic [COORD_BITS-1:0] hi);
      extent = (hi >= lo) ? ({1'b0, hi} - {1'b0, lo} + 1'b1) : '0;
   endfunction

   // stage 1: extents
   logic [COORD_BITS-1:0] kl, kt, kr, kb;
   logic [LABEL_W-1:0]    klab;
   assign {klab, kb, kr, kt, kl} = rd_ff;

   logic [EW-1:0] iw_ff, ih_ff, kw_ff, kh_ff;
   logic          same_ff;
   logic [AR-1:0] area_a_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         iw_ff <= extent((bl > kl) ? bl : kl, (br < kr) ? br : kr);
         ih_ff <= extent((bt > kt) ? bt : kt, (bb < kb) ? bb : kb);
         kw_ff <= extent(kl, kr);
         kh_ff <= extent(kt, kb);
         same_ff <= (klab == box_ff.class_label);
      end
      if (capture)
         area_a_ff <= '0;
      else if (state_ff == S_READ)
         area_a_ff <= extent(bl, br) * extent(bt, bb);
   end

   // stage 2: areas
   logic [AR-1:0] inter_ff, area_k_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_MULT) begin
         inter_ff  <= iw_ff * ih_ff;
         area_k_ff <= kw_ff * kh_ff;
      end
   end

   // stage 3: threshold compare, inter*65536 >= thr*union
   logic [UW-1:0]       uni;
   logic [UW+IOU_W-1:0] lhs, rhs;
   logic                hit;
   assign uni = {1'b0, area_a_ff} + {1'b0, area_k_ff} - {1'b0, inter_ff};
   assign lhs = {{(UW+IOU_W-AR-16){1'b0}}, inter_ff, 16'd0};
   assign rhs = UW'(uni) * (UW+IOU_W)'(iou_ff);
   assign hit = same_ff && (uni != '0) && (lhs >= rhs);

   assign capture = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (capture) begin
               state_in = S_READ;
               scan_in  = '0;
               if (req.data.start_req) count_in = '0;
            end
         end
         S_READ: begin
            if (box_ff.score <= sthr_ff) begin
               stat_in  = ST_BELOW;
               state_in = S_DONE;
            end else if (scan_ff >= count_ff) begin
               if (CW'(count_ff) >= CW'(limit_ff) && {{(LIMIT_W){1'b0}}, count_ff}
                     >= {{(CW){1'b0}}, limit_ff}) begin
                  stat_in = ST_LIMIT;
               end else if (count_ff >= CW'(MAX_KEPT)) begin
                  stat_in = ST_FULL;
               end else begin
                  stat_in  = ST_KEPT;
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: state_in = S_MULT;
         S_MULT: state_in = S_CMP;
         S_CMP: begin
            if (hit) begin
               stat_in  = ST_SUPPR;
               state_in = S_DONE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
         stat_ff  <= ST_BELOW;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         stat_ff  <= stat_in;
      end
      if (capture) box_ff <= req.data;
   end

   assign rsp.valid = (state_ff == S_DONE);
   assign rsp.data.out_index = box_ff.box_index;
   assign rsp.data.out_label = box_ff.class_label;
   assign rsp.data.out_score = box_ff.score;
   assign rsp.data.status    = stat_ff;
endmodule

FILE: rtl/gbn_checker.sv
// Checker: port-level properties of the suppression block, with its bind.
`timescale 1ns / 1ps
module gbn_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status
);
   import gbn_pkg::*;

   // one request in flight: no new request while a response waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   // a response holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");

   // status is a legal code
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");

   // a response is followed by readiness
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready) else $error("not ready after response");
endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status)
);

FILE: sim/tb_greedy_box_nms.sv
// Testbench: greedy box suppression checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_greedy_box_nms;
   import gbn_pkg::*;

   localparam int KEEP_DEPTH = MAX_KEPT_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam int REQ_W = $bits(req_type);

   // Scoreboard: own copy of the kept store and registers, queue of expected responses
   class nms_scoreboard;
      logic [IOU_W-1:0]   iou_thr;
      logic [SCORE_W-1:0] score_bar;
      logic [LIMIT_W-1:0] keep_limit;
      logic [63:0]        kept_box [KEEP_DEPTH];
      logic [LABEL_W-1:0] kept_cls [KEEP_DEPTH];
      int                 kept_num;
      rsp_type            pending [$];
      int                 errors;

      function new();
         iou_thr = IOU_RESET;
         score_bar = SCORE_RESET;
         keep_limit = LIMIT_RESET;
         kept_num = 0;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_IOU: iou_thr = value[IOU_W-1:0];
            CSR_SCORE: score_bar = value[SCORE_W-1:0];
            CSR_LIMIT: keep_limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint span(longint lo, longint hi);
         return (hi >= lo) ? hi - lo + 1 : 0;
      endfunction

      // Overlap test without division: inter * 65536 >= thr * union
      function bit overlapping(logic [63:0] k, req_type r);
         longint kl, kt, kr, kb, a_new, a_old, inter, uni;
         kl = k[15:0]; kt = k[31:16]; kr = k[47:32]; kb = k[63:48];
         a_new = span(r.left, r.right) * span(r.top, r.bottom);
         a_old = span(kl, kr) * span(kt, kb);
         inter = span(r.left > kl ? r.left : kl, r.right < kr ? r.right : kr) *
                 span(r.top > kt ? r.top : kt, r.bottom < kb ? r.bottom : kb);
         uni = a_new + a_old - inter;
         if (uni == 0) return 0;
         return inter * 65536 >= longint'(iou_thr) * uni;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         bit supp;
         supp = 0;
         if (r.start_req) kept_num = 0;
         e.out_index = r.box_index;
         e.out_label = r.class_label;
         e.out_score = r.score;
         if (r.score <= score_bar) begin
            e.status = ST_BELOW;
         end else begin
            for (int i = 0; i < kept_num; i++)
               if (!supp && kept_cls[i] == r.class_label && overlapping(kept_box[i], r))
                  supp = 1;
            if (supp) e.status = ST_SUPPR;
            else if (kept_num >= keep_limit) e.status = ST_LIMIT;
            else if (kept_num >= KEEP_DEPTH) e.status = ST_FULL;
            else begin
               kept_box[kept_num] = {r.bottom, r.right, r.top, r.left};
               kept_cls[kept_num] = r.class_label;
               kept_num++;
               e.status = ST_KEPT;
            end
         end
         pending = {pending, e};
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response index %0d", a.out_index);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.out_index !== e.out_index) begin
            $error("out_index exp %0d got %0d", e.out_index, a.out_index); errors++;
         end
         if (a.out_label !== e.out_label) begin
            $error("out_label exp %0d got %0d", e.out_label, a.out_label); errors++;
         end
         if (a.out_score !== e.out_score) begin
            $error("out_score exp %0d got %0d", e.out_score, a.out_score); errors++;
         end
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   gbn_req_if req_if();
   gbn_rsp_if rsp_if();
   gbn_csr_if csr_if();

   greedy_box_nms uut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source), .csr(csr_if.sink)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   nms_scoreboard sb = new();
   bit idle_free = 0;     // stretch with no idling on either side
   bit hold_go = 0;       // raised once by the stimulus to start the long stall
   bit hold_done = 0;
   int hold_off = 0;      // long receiver stall, counted below
   int quiet_cycles = 0;

   initial begin
      req_if.valid = 0; req_if.data = '0;
      csr_if.valid = 0; csr_if.data = '0;
      rsp_if.ready = 0;
   end

   // Receiver: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 0;
      else if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_off <= 400;
         rsp_if.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_if.ready <= 0;
      end else rsp_if.ready <= idle_free || ($urandom_range(99) >= 25);
   end

   // Check every accepted response; watchdog on accepted traffic
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // valid stays up after acceptance so back-to-back requests see no gap
   task automatic send_request(req_type r);
      while (!idle_free && $urandom_range(99) < 25) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.data <= r;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_if.valid <= 1;
      csr_if.data <= '{index: idx, data: value};
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, value);
      csr_if.valid <= 0;
      @(posedge clock);
   endtask

   // Wait for all responses, then the longest scan time before touching registers
   task automatic drain();
      req_if.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4 * KEEP_DEPTH + 16) @(posedge clock);
   endtask

   function automatic req_type make_box(bit st, int cls, int sc, int l, int t, int w, int h);
      req_type r;
      r.start_req = st;
      r.box_index = 16'($urandom);
      r.class_label = 8'(cls);
      r.score = 16'(sc);
      r.left = 16'(l); r.top = 16'(t);
      r.right = 16'(l + w); r.bottom = 16'(t + h);
      return r;
   endfunction

   // Random set: clusters of near-duplicate boxes in a few classes, some noise
   task automatic random_set(int n);
      req_type r, base;
      logic [15:0] sc;
      sc = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         if (i == 0 || $urandom_range(3) == 0)
            base = make_box(0, $urandom_range(3), 0, $urandom_range(1000),
                            $urandom_range(1000), $urandom_range(60), $urandom_range(60));
         if ($urandom_range(9) == 0) begin
            r = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
            r.start_req = 0;
         end else begin
            r = base;
            r.box_index = 16'($urandom);
            r.left = base.left + 16'($urandom_range(20));
            r.top = base.top + 16'($urandom_range(20));
            r.right = base.right + 16'($urandom_range(20));
            r.bottom = base.bottom + 16'($urandom_range(20));
            sc = sc - 16'($urandom_range(300));
            r.score = sc;
         end
         r.start_req = (i == 0);
         send_request(r);
      end
   endtask

   initial begin
      req_type r;
      int sent;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset thresholds, extremes, inverted corners, zero union
      send_request(make_box(1, 0, 16'hFFFF, 0, 0, 10, 10));
      send_request(make_box(0, 0, 16'hFFF0, 2, 2, 10, 10));
      send_request(make_box(0, 1, 16'hFFE0, 2, 2, 10, 10));
      send_request(make_box(0, 0, 0, 0, 0, 10, 10));
      r = make_box(0, 2, 100, 50, 50, 0, 0);
      r.right = 16'd40; r.bottom = 16'd40;
      send_request(r);
      r.box_index = 16'hFFFF;
      send_request(r);
      r = make_box(0, 8'hFF, 16'hFFFF, 16'hFFF0, 16'hFFF0, 15, 15);
      send_request(r);
      r.box_index = '0;
      send_request(r);
      send_request(make_box(0, 8'hFF, 16'h8000, 0, 0, 16'hFFFF, 16'hFFFF));
      drain();
      // Threshold zero, threshold above one, high score bar, tiny limit
      write_csr(CSR_IOU, 0);
      write_csr(CSR_SCORE, 32'hFFFE);
      write_csr(CSR_LIMIT, 2);
      send_request(make_box(1, 3, 16'hFFFF, 0, 0, 5, 5));
      send_request(make_box(0, 3, 16'hFFFF, 900, 900, 5, 5));
      send_request(make_box(0, 3, 16'hFFFE, 900, 900, 5, 5));
      send_request(make_box(0, 4, 16'hFFFF, 900, 900, 5, 5));
      send_request(make_box(0, 5, 16'hFFFF, 100, 100, 5, 5));
      drain();
      write_csr(CSR_IOU, 32'h1FFFF);
      write_csr(CSR_SCORE, 0);
      write_csr(CSR_LIMIT, 0);
      send_request(make_box(1, 3, 1, 0, 0, 5, 5));
      drain();
      write_csr(csr_index_type'(2'd3), 32'h5);
      write_csr(CSR_LIMIT, 32'h1FF);

      // Fill the store to capacity with identical boxes at an unreachable threshold
      for (int i = 0; i < KEEP_DEPTH + 3; i++)
         send_request(make_box(i == 0, 7, 16'hFFFF, 10, 10, 3, 3));
      drain();

      // Long receiver hold-off with the sender still pushing
      write_csr(CSR_IOU, 32'd65536);
      write_csr(CSR_LIMIT, 300);
      hold_go = 1;
      random_set(30);
      drain();

      // Random phases across several register settings
      sent = 0;
      for (int ph = 0; sent < 1300; ph++) begin
         write_csr(CSR_IOU, (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 65536 : $urandom_range(65536));
         write_csr(CSR_SCORE, (ph % 3 == 0) ? 0 : $urandom_range(65535));
         write_csr(CSR_LIMIT, (ph % 5 == 0) ? 256 : $urandom_range(1, 40));
         idle_free = (ph == 3);
         for (int s = 0; s < 10; s++) begin
            int n;
            n = $urandom_range(5, 25);
            random_set(n);
            sent += n;
         end
         drain();
         idle_free = 0;
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

FILE: sim.f
rtl/gbn_pkg.sv
rtl/gbn_if.sv
rtl/greedy_box_nms.sv
rtl/gbn_checker.sv
sim/tb_greedy_box_nms.sv
